/* hw/rtl/bsd_pkg.sv */
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared types and constants of the breath segment detector: window sizes,
// field widths, configuration register indexes and the structs that pass
// between the detector's submodules.
// ----------------------------------------------------------------------------
package bsd_pkg;

  // Window store geometry (depth must stay a power of two: pointers wrap)
  localparam int MaxWindow = 32;
  localparam int WinAw     = $clog2(MaxWindow);
  localparam int WinCw     = $clog2(MaxWindow + 1);

  // Field widths
  localparam int SampleW = 16;
  localparam int Med2W   = SampleW + 1;
  localparam int DiffW   = SampleW + 2;
  localparam int CleanW  = 18;
  localparam int IdxW    = 32;
  localparam int AreaW   = 48;
  localparam int RunW    = 8;
  localparam int CfgW    = 16;

  typedef logic signed [SampleW-1:0] sample_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgWindowLen  = 2'd0,
    CfgZeroLevel  = 2'd1,
    CfgZeroSigma  = 2'd2,
    CfgMinZeroRun = 2'd3
  } cfg_idx_e;

  // Window read request
  typedef struct packed {
    logic             re;
    logic [WinAw-1:0] addr;
  } win_rd_t;

  // Settings seen by the segmenter (run already forced to at least one)
  typedef struct packed {
    sample_t             base_level;
    logic [CfgW-1:0]     dead_band;
    logic [RunW-1:0]     run;
  } seg_cfg_t;

  // One result word
  typedef struct packed {
    logic signed [CleanW-1:0] clean;
    logic [IdxW-1:0]          index;
    logic                     done;
    logic [IdxW-1:0]          seg_start;
    logic [IdxW-1:0]          seg_end;
    logic signed [AreaW-1:0]  area;
  } seg_res_t;

endpackage

/* hw/rtl/bsd_window.sv */
// ----------------------------------------------------------------------------
// bsd_window
// Sample window store: one write port, one read port with registered data.
// Entries are undefined until written.
// ----------------------------------------------------------------------------
module bsd_window
  import bsd_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [WinAw-1:0] waddr_i,
  input  sample_t          wdata_i,
  input  win_rd_t          rd_i,
  output sample_t          rd_data_o
);

  sample_t mem_q [MaxWindow];
  sample_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      rd_data_q <= mem_q[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/bsd_median.sv */
// ----------------------------------------------------------------------------
// bsd_median
// Rank selection median at twice scale. For each candidate of the window one
// pass reads every entry and compares it with the candidate through a single
// shared comparator; ties are broken by age. Candidates whose rank is the
// lower or upper middle are kept, and their sum is the doubled median.
// ----------------------------------------------------------------------------
module bsd_median
  import bsd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [WinCw-1:0]        win_len_i,
  input  logic [WinAw-1:0]        wr_ptr_i,
  output win_rd_t                 rd_o,
  input  sample_t                 rd_data_i,
  output logic                    done_o,
  output logic signed [Med2W-1:0] med2_o
);

  // issue side
  logic             busy_q;
  logic [WinCw-1:0] j_q;   // candidate age
  logic [WinCw-1:0] k_q;   // 0: candidate read, else compare with age k-1
  logic [WinCw-1:0] age;
  logic             pass_end;
  logic             cand_last;

  // data side (the cycle after the read)
  logic             p_vld_q;
  logic             p_cand_q;
  logic             p_last_q;
  logic             p_final_q;
  logic [WinAw-1:0] p_age_q;
  logic             done_q;

  sample_t          cand_q;
  logic [WinAw-1:0] cage_q;
  logic [WinAw-1:0] rank_q;
  sample_t          lo_q;
  sample_t          hi_q;

  logic             less;
  logic [WinAw-1:0] rank_nx;
  logic [WinCw-1:0] hi_rank;
  logic [WinCw-1:0] lo_rank;

  // read address: age 0 is the newest sample
  assign age       = (k_q == '0) ? j_q : k_q - WinCw'(1);
  assign pass_end  = (k_q == win_len_i);
  assign cand_last = (j_q == win_len_i - WinCw'(1));
  assign rd_o.re   = busy_q;
  assign rd_o.addr = wr_ptr_i - WinAw'(1) - age[WinAw-1:0];

  // shared comparator and rank count
  assign less    = (rd_data_i < cand_q) || ((rd_data_i == cand_q) && (p_age_q < cage_q));
  assign rank_nx = rank_q + WinAw'(less);
  assign hi_rank = win_len_i >> 1;
  assign lo_rank = win_len_i[0] ? hi_rank : hi_rank - WinCw'(1);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      j_q       <= '0;
      k_q       <= '0;
      p_vld_q   <= 1'b0;
      p_cand_q  <= 1'b0;
      p_last_q  <= 1'b0;
      p_final_q <= 1'b0;
      p_age_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      p_vld_q   <= busy_q;
      p_cand_q  <= (k_q == '0);
      p_last_q  <= pass_end;
      p_final_q <= cand_last;
      p_age_q   <= age[WinAw-1:0];
      done_q    <= p_vld_q && p_last_q && p_final_q;
      if (start_i) begin
        busy_q <= 1'b1;
        j_q    <= '0;
        k_q    <= '0;
      end else if (busy_q) begin
        if (pass_end) begin
          k_q <= '0;
          if (cand_last) begin
            busy_q <= 1'b0;
          end else begin
            j_q <= j_q + WinCw'(1);
          end
        end else begin
          k_q <= k_q + WinCw'(1);
        end
      end
    end
  end

  // candidate, rank and middle values
  always_ff @(posedge clk_i) begin
    if (p_vld_q) begin
      if (p_cand_q) begin
        cand_q <= rd_data_i;
        cage_q <= p_age_q;
        rank_q <= '0;
      end else begin
        rank_q <= rank_nx;
        if (p_last_q) begin
          if ({1'b0, rank_nx} == lo_rank) begin
            lo_q <= cand_q;
          end
          if ({1'b0, rank_nx} == hi_rank) begin
            hi_q <= cand_q;
          end
        end
      end
    end
  end

  assign done_o = done_q;
  assign med2_o = {lo_q[SampleW-1], lo_q} + {hi_q[SampleW-1], hi_q};

endmodule

/* hw/rtl/bsd_segment.sv */
// ----------------------------------------------------------------------------
// bsd_segment
// Dead zone and segmenter. Three steps per word: baseline difference, dead
// zone, then the zero-run / segment state update with a saturating area sum.
// ----------------------------------------------------------------------------
module bsd_segment
  import bsd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    go_i,
  input  seg_cfg_t                cfg_i,
  input  logic signed [Med2W-1:0] med2_i,
  output logic                    upd_o,
  output seg_res_t                res_o
);

  typedef enum logic [1:0] {
    SegIdle,
    SegDiff,
    SegClean,
    SegUpdate
  } seg_state_e;

  typedef enum logic [1:0] {
    ModeWait,
    ModeArmed,
    ModeSeg
  } seg_mode_e;

  localparam logic signed [AreaW-1:0] AreaMax = {1'b0, {(AreaW-1){1'b1}}};
  localparam logic signed [AreaW-1:0] AreaMin = {1'b1, {(AreaW-1){1'b0}}};

  seg_state_e state_q;
  seg_mode_e  mode_q, mode_d;

  logic signed [DiffW-1:0]  d_q;
  logic signed [CleanW-1:0] clean_q;
  logic [RunW-1:0]          zr_q, zr_d;
  logic [IdxW-1:0]          idx_q;
  logic [IdxW-1:0]          start_q, start_d;
  logic signed [AreaW-1:0]  acc_q, acc_d;

  logic [DiffW-1:0]         sig2;
  logic                     dead;
  logic [RunW-1:0]          zr_inc;
  logic signed [AreaW:0]    sum;
  logic signed [AreaW-1:0]  sum_sat;
  seg_res_t                 res;

  // dead zone test
  assign sig2 = {1'b0, cfg_i.dead_band, 1'b0};
  assign dead = d_q[DiffW-1] || (d_q < $signed(sig2));

  // saturating area add
  assign sum     = {acc_q[AreaW-1], acc_q} + {{(AreaW+1-CleanW){clean_q[CleanW-1]}}, clean_q};
  assign sum_sat = (sum[AreaW] != sum[AreaW-1]) ? (sum[AreaW] ? AreaMin : AreaMax)
                                                : sum[AreaW-1:0];
  assign zr_inc  = (zr_q == {RunW{1'b1}}) ? zr_q : zr_q + RunW'(1);

  // segment state update
  always_comb begin
    mode_d        = mode_q;
    zr_d          = zr_q;
    start_d       = start_q;
    acc_d         = acc_q;
    res           = '0;
    res.clean     = clean_q;
    res.index     = idx_q;
    if (clean_q == '0) begin
      zr_d = zr_inc;
      unique case (mode_q)
        ModeWait: begin
          if (zr_inc >= cfg_i.run) begin
            mode_d = ModeArmed;
          end
        end
        ModeSeg: begin
          if (zr_inc >= cfg_i.run) begin
            res.done      = 1'b1;
            res.seg_start = start_q;
            res.seg_end   = idx_q - IdxW'(zr_inc) + IdxW'(1);
            res.area      = acc_q;
            mode_d        = ModeArmed;
            acc_d         = '0;
          end
        end
        default: mode_d = ModeArmed;
      endcase
    end else begin
      zr_d = '0;
      unique case (mode_q)
        ModeArmed: begin
          mode_d  = ModeSeg;
          start_d = idx_q;
          acc_d   = AreaW'(clean_q);
        end
        ModeSeg: acc_d = sum_sat;
        default: mode_d = ModeWait;
      endcase
    end
  end

  // step sequencer and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SegIdle;
      mode_q  <= ModeWait;
      zr_q    <= '0;
      idx_q   <= '0;
      start_q <= '0;
      acc_q   <= '0;
    end else begin
      unique case (state_q)
        SegIdle: begin
          if (go_i) begin
            state_q <= SegDiff;
          end
        end
        SegDiff:  state_q <= SegClean;
        SegClean: state_q <= SegUpdate;
        SegUpdate: begin
          state_q <= SegIdle;
          mode_q  <= mode_d;
          zr_q    <= zr_d;
          idx_q   <= idx_q + IdxW'(1);
          start_q <= start_d;
          acc_q   <= acc_d;
        end
        default: state_q <= SegIdle;
      endcase
    end
  end

  // datapath steps
  always_ff @(posedge clk_i) begin
    if (state_q == SegIdle && go_i) begin
      d_q <= {cfg_i.base_level[SampleW-1], cfg_i.base_level, 1'b0}
             - {med2_i[Med2W-1], med2_i};
    end
    if (state_q == SegDiff) begin
      clean_q <= dead ? '0 : -d_q;
    end
  end

  assign upd_o = (state_q == SegUpdate);
  assign res_o = res;

endmodule

/* hw/rtl/breath_segment_detector_core.sv */
// ----------------------------------------------------------------------------
// breath_segment_detector_core
// A taken sample runs through the single-comparator median (w+1 reads per
// candidate, w the effective window length) and then the segmenter steps
// before its result word is raised. The input stalls until the word is in
// the output register; a finished word may wait there while the next sample is
// taken. Samples that leave the window short give no word and do not stall
// the input. Reset clears all control state.
// ----------------------------------------------------------------------------
module breath_segment_detector_core
  import bsd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [CfgW-1:0]          cfg_wdata_i,
  // sample channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [SampleW-1:0] sample_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [CleanW-1:0] clean_value_o,
  output logic [IdxW-1:0]          sample_index_o,
  output logic                     segment_done_o,
  output logic [IdxW-1:0]          segment_start_o,
  output logic [IdxW-1:0]          segment_end_o,
  output logic signed [AreaW-1:0]  segment_area_o
);

  typedef enum logic [1:0] {
    TopIdle,
    TopMedian,
    TopWait,
    TopSegment
  } top_state_e;

  top_state_e state_q;

  // configuration registers
  logic [WinCw-1:0] win_len_q;
  sample_t          base_level_q;
  logic [CfgW-1:0]  dead_band_q;
  logic [RunW-1:0]  min_run_q;

  logic [WinCw-1:0] fill_q;
  logic [WinAw-1:0] wp_q;
  logic             out_valid_q;
  seg_res_t         out_q;

  logic             in_acc;
  logic [WinCw-1:0] fill_nx;
  logic [WinCw-1:0] w_eff;
  logic             med_start;
  logic             out_free;
  logic             seg_go;
  seg_cfg_t         seg_cfg;

  win_rd_t                 win_rd;
  sample_t                 win_rd_data;
  logic                    med_done;
  logic signed [Med2W-1:0] med2;
  logic                    seg_upd;
  seg_res_t                seg_res;

  // handshakes and window bookkeeping
  assign in_stall_o = (state_q != TopIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign fill_nx    = (fill_q == WinCw'(MaxWindow)) ? fill_q : fill_q + WinCw'(1);
  assign w_eff      = (win_len_q == '0) ? WinCw'(1)
                    : (win_len_q > WinCw'(MaxWindow)) ? WinCw'(MaxWindow) : win_len_q;
  assign med_start  = in_acc && (fill_nx >= w_eff);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign seg_go     = (state_q == TopWait) && out_free;

  assign seg_cfg.base_level = base_level_q;
  assign seg_cfg.dead_band  = dead_band_q;
  assign seg_cfg.run        = (min_run_q == '0) ? RunW'(1) : min_run_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q    <= WinCw'(5);
      base_level_q <= '0;
      dead_band_q  <= '0;
      min_run_q    <= RunW'(5);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgWindowLen:  win_len_q    <= cfg_wdata_i[WinCw-1:0];
        CfgZeroLevel:  base_level_q <= cfg_wdata_i;
        CfgZeroSigma:  dead_band_q  <= cfg_wdata_i;
        CfgMinZeroRun: min_run_q    <= cfg_wdata_i[RunW-1:0];
        default: ;
      endcase
    end
  end

  // control sequencer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TopIdle;
      fill_q      <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        TopIdle: begin
          if (in_acc) begin
            fill_q <= fill_nx;
            wp_q   <= wp_q + WinAw'(1);
            if (med_start) begin
              state_q <= TopMedian;
            end
          end
        end
        TopMedian: begin
          if (med_done) begin
            state_q <= TopWait;
          end
        end
        TopWait: begin
          if (seg_go) begin
            state_q <= TopSegment;
          end
        end
        TopSegment: begin
          if (seg_upd) begin
            out_valid_q <= 1'b1;
            state_q     <= TopIdle;
          end
        end
        default: state_q <= TopIdle;
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (seg_upd) begin
      out_q <= seg_res;
    end
  end

  bsd_window u_window (
    .clk_i     (clk_i),
    .we_i      (in_acc),
    .waddr_i   (wp_q),
    .wdata_i   (sample_i),
    .rd_i      (win_rd),
    .rd_data_o (win_rd_data)
  );

  bsd_median u_median (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (med_start),
    .win_len_i (w_eff),
    .wr_ptr_i  (wp_q),
    .rd_o      (win_rd),
    .rd_data_i (win_rd_data),
    .done_o    (med_done),
    .med2_o    (med2)
  );

  bsd_segment u_segment (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (seg_go),
    .cfg_i  (seg_cfg),
    .med2_i (med2),
    .upd_o  (seg_upd),
    .res_o  (seg_res)
  );

  assign out_valid_o     = out_valid_q;
  assign clean_value_o   = out_q.clean;
  assign sample_index_o  = out_q.index;
  assign segment_done_o  = out_q.done;
  assign segment_start_o = out_q.seg_start;
  assign segment_end_o   = out_q.seg_end;
  assign segment_area_o  = out_q.area;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for breath_segment_detector_core. Raw samples go in
// through the valid/stall channel. A scoreboard keeps its own copy of the
// median window, the dead zone and the segment state. It predicts one word
// per sample once the window is full. Each word that leaves the block is
// compared field by field with the oldest prediction. The run moves through
// several register settings, the extremes among them, and idles and stalls
// both channels at random.
// ----------------------------------------------------------------------------
module testbench;
  import bsd_pkg::*;

  localparam longint AreaTop    = 64'sh7FFF_FFFF_FFFF;
  localparam longint AreaBottom = -AreaTop - 1;
  localparam longint CleanFloor = -131072;

  typedef enum {SegWait, SegArmed, SegInside} seg_mode_e;

  // Register settings and length of one phase of the run
  typedef struct {
    int w;
    int zl;
    int sig;
    int run;
    int n;
    bit calm;
  } phase_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirror of the detector state plus the words still to come
  // --------------------------------------------------------------------------
  class seg_scoreboard;
    int            win_len_reg;
    int            level;
    int            sigma;
    int            run_reg;
    int            store [MaxWindow];
    int            filled;
    int            wr_ptr;
    bit [IdxW-1:0] next_index;
    bit [IdxW-1:0] start_at;
    int            zeros;
    seg_mode_e     mode;
    longint        area;
    seg_res_t      pending_words [$];
    int unsigned   faults;

    function new();
      win_len_reg = 5;
      level       = 0;
      sigma       = 0;
      run_reg     = 5;
      filled      = 0;
      wr_ptr      = 0;
      next_index  = '0;
      start_at    = '0;
      zeros       = 0;
      mode        = SegWait;
      area        = 0;
      faults      = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgW-1:0] v);
      case (idx)
        CfgWindowLen:  win_len_reg = int'(v[5:0]);
        CfgZeroLevel:  level       = int'($signed(v));
        CfgZeroSigma:  sigma       = int'(v);
        CfgMinZeroRun: run_reg     = int'(v[7:0]);
        default: ;
      endcase
    endfunction

    // Window length as the block uses it
    function int window_span();
      if (win_len_reg == 0) return 1;
      if (win_len_reg > MaxWindow) return MaxWindow;
      return win_len_reg;
    endfunction

    // Median of the newest w samples at twice scale
    function longint median_x2(int w);
      int sorted [MaxWindow];
      int x;
      int j;
      for (int k = 0; k < w; k++) begin
        x = store[(wr_ptr + MaxWindow - 1 - k) % MaxWindow];
        j = k;
        while (j > 0 && sorted[j-1] > x) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = x;
      end
      if (w % 2 == 0) return longint'(sorted[w/2-1]) + longint'(sorted[w/2]);
      return 2 * longint'(sorted[w/2]);
    endfunction

    // Accepted sample: update the mirror, queue the word it causes
    function void take_sample(logic signed [SampleW-1:0] s);
      int       w;
      int       run;
      longint   d;
      longint   clean;
      longint   sum;
      seg_res_t word;
      w   = window_span();
      run = (run_reg == 0) ? 1 : run_reg;
      store[wr_ptr] = int'(s);
      wr_ptr = (wr_ptr + 1) % MaxWindow;
      if (filled < MaxWindow) filled++;
      if (filled < w) return;

      // dead zone
      d = 2 * longint'(level) - median_x2(w);
      if (d < 0 || d < 2 * longint'(sigma)) clean = 0;
      else clean = -d;
      if (clean < CleanFloor) clean = CleanFloor;

      word       = '0;
      word.clean = clean[CleanW-1:0];
      word.index = next_index;
      next_index = next_index + 1;

      // segmenter
      if (clean == 0) begin
        if (zeros < 255) zeros++;
        case (mode)
          SegWait: begin
            if (zeros >= run) mode = SegArmed;
          end
          SegInside: begin
            if (zeros >= run) begin
              word.done      = 1'b1;
              word.seg_start = start_at;
              word.seg_end   = word.index - IdxW'(zeros) + 32'd1;
              word.area      = area[AreaW-1:0];
              mode           = SegArmed;
              area           = 0;
            end
          end
          default: mode = SegArmed;
        endcase
      end else begin
        zeros = 0;
        case (mode)
          SegArmed: begin
            mode     = SegInside;
            start_at = word.index;
            area     = clean;
          end
          SegInside: begin
            sum = area + clean;
            if (sum < AreaBottom) sum = AreaBottom;
            if (sum > AreaTop) sum = AreaTop;
            area = sum;
          end
          default: mode = SegWait;
        endcase
      end
      pending_words.insert(pending_words.size(), word);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        faults++;
      end
    endfunction

    function void check_word(seg_res_t got);
      seg_res_t want;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual index %0h",
                 $time, got.index);
        faults++;
        return;
      end
      want = pending_words.pop_front();
      compare_field("clean_value", want.clean, got.clean);
      compare_field("sample_index", want.index, got.index);
      compare_field("segment_done", want.done, got.done);
      compare_field("segment_start", want.seg_start, got.seg_start);
      compare_field("segment_end", want.seg_end, got.seg_end);
      compare_field("segment_area", want.area, got.area);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [1:0]                cfg_idx_i   = CfgWindowLen;
  logic [CfgW-1:0]           cfg_wdata_i = '0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic signed [SampleW-1:0] sample_i    = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [CleanW-1:0]  clean_value_o;
  logic [IdxW-1:0]           sample_index_o;
  logic                      segment_done_o;
  logic [IdxW-1:0]           segment_start_o;
  logic [IdxW-1:0]           segment_end_o;
  logic signed [AreaW-1:0]   segment_area_o;

  bit            calm = 1'b0;
  seg_scoreboard sb;

  breath_segment_detector_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .clean_value_o   (clean_value_o),
    .sample_index_o  (sample_index_o),
    .segment_done_o  (segment_done_o),
    .segment_start_o (segment_start_o),
    .segment_end_o   (segment_end_o),
    .segment_area_o  (segment_area_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side stalls at random with odds of 6 in 100, none while calm
  always @(posedge clk_i) begin
    out_stall_i <= calm ? 1'b0 : ($urandom_range(0, 99) < 6);
  end

  // Monitor: both handshakes seen at the same edge as the block sees them
  always @(posedge clk_i) begin
    seg_res_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.clean     = clean_value_o;
        got.index     = sample_index_o;
        got.done      = segment_done_o;
        got.seg_start = segment_start_o;
        got.seg_end   = segment_end_o;
        got.area      = segment_area_o;
        sb.check_word(got);
      end
      if (in_valid_i && !in_stall_o) sb.take_sample(sample_i);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic send_sample(logic signed [SampleW-1:0] s);
    if (!calm && $urandom_range(0, 99) < 6) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic put_reg(cfg_idx_e idx, logic [CfgW-1:0] v);
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    sb.write_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic configure(phase_t p);
    cfg_we_i <= 1'b1;
    put_reg(CfgWindowLen, CfgW'(p.w));
    put_reg(CfgZeroLevel, CfgW'(p.zl));
    put_reg(CfgZeroSigma, CfgW'(p.sig));
    put_reg(CfgMinZeroRun, CfgW'(p.run));
    cfg_we_i <= 1'b0;
  endtask

  // Let every word out, then give a short-window sample time to settle
  task automatic drain();
    int ew;
    in_valid_i <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk_i);
    ew = sb.window_span();
    repeat (ew * (ew + 1) + 20) @(posedge clk_i);
  endtask

  // Sample that the dead zone maps to zero
  function automatic logic signed [SampleW-1:0] pick_quiet(phase_t p);
    int lo;
    lo = (p.sig == 0) ? p.zl : p.zl - p.sig + 1;
    if (lo < -32768) lo = -32768;
    return SampleW'(lo + int'($urandom_range(0, 32767 - lo)));
  endfunction

  // Sample that lies far enough below the baseline to count as flow, else the lowest sample
  function automatic logic signed [SampleW-1:0] pick_breath(phase_t p);
    int hi;
    hi = p.zl - ((p.sig == 0) ? 1 : p.sig);
    if (hi < -32768) hi = -32768;
    return SampleW'(-32768 + int'($urandom_range(0, hi + 32768)));
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Opening words at reset settings: field extremes, window fill, arming,
  // a segment opening and closing, and the closing run arming the next one
  sample_t opening [25] = '{
    16'sh7FFF, -16'sh8000, 0, 0, 0, 0, 0, 0, 0,
    -16'sh8000, -16'sh8000, -16'sh8000, -100, -16'sh8000,
    0, 0, 0, 0, 0, 0, 0, 1, -1, 16'sh5555, -16'sh5556
  };

  phase_t plan [9] = '{
    '{0,      0,     0,   0, 150, 1'b0},  // window and run of zero
    '{3,  -1000,   200,   3, 200, 1'b0},
    '{2,    500,    10,   4, 200, 1'b0},  // even window
    '{4,  32767, 65535,   2, 150, 1'b0},  // widest dead zone
    '{1,    100,    50, 255, 600, 1'b0},  // longest zero run
    '{7, -32768,     0,   6,  60, 1'b0},  // lowest baseline
    '{32,     0,  1000,   8,  40, 1'b0},  // full window
    '{63,  -300,     0,   5,  40, 1'b0},  // window beyond the store
    '{6,   2000,     0,   5, 250, 1'b1}   // no idling
  };

  initial begin
    int sent;
    int ew;
    int run;
    int zlen;
    int blen;
    int roll;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (opening[i]) send_sample(opening[i]);
    drain();

    foreach (plan[ph]) begin
      calm = plan[ph].calm;
      configure(plan[ph]);
      ew   = sb.window_span();
      run  = (plan[ph].run == 0) ? 1 : plan[ph].run;
      sent = 0;
      while (sent < plan[ph].n) begin
        roll = $urandom_range(0, 99);
        if (roll < 90) begin
          // quiet run then a burst of flow; short runs break the pattern
          if (roll < 80) begin
            zlen = run + ew + $urandom_range(0, 3);
            blen = $urandom_range(1, 2 * ew + 6);
          end else begin
            zlen = $urandom_range(0, run);
            blen = $urandom_range(1, ew + 2);
          end
          for (int k = 0; k < zlen && sent < plan[ph].n; k++) begin
            send_sample(pick_quiet(plan[ph]));
            sent++;
          end
          for (int k = 0; k < blen && sent < plan[ph].n; k++) begin
            send_sample(pick_breath(plan[ph]));
            sent++;
          end
        end else begin
          // raw noise over the whole sample range
          blen = $urandom_range(1, 8);
          for (int k = 0; k < blen && sent < plan[ph].n; k++) begin
            send_sample(SampleW'($urandom()));
            sent++;
          end
        end
      end
      drain();
    end

    if (sb.faults == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
